@@ sv/pcl_pkg.sv @@
// Package for the positional byte list: field widths, operation and status
// codes, controller states and the controller/datapath interface structs.
// No dependencies.
package pcl_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FUNC_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 8;
  localparam int STAT_W = 2;
  localparam int IN_W = 24;
  localparam int OUT_W = 24;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCATE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

  typedef logic [POS_W:0] pos_ext_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND
  } state_t;

  typedef struct packed {
    logic load_op;
    logic scan;
    logic commit;
    logic find;
  } cmd_t;

  typedef struct packed {
    logic is_locate;
    logic out_free;
  } stat_t;

endpackage

@@ sv/pcl_ctrl.sv @@
// Controller for the positional byte list: sequences accept, execute and
// locate search, and gates result writes on a free output register.
// Depends on pcl_pkg.
module pcl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  pcl_pkg::stat_t stat,
  output pcl_pkg::cmd_t  cmd
);

  pcl_pkg::state_t state;
  pcl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcl_pkg::S_IDLE: begin
        if (s_tvalid) state_next = pcl_pkg::S_EXEC;
      end
      pcl_pkg::S_EXEC: begin
        if (stat.is_locate) state_next = pcl_pkg::S_FIND;
        else if (stat.out_free) state_next = pcl_pkg::S_IDLE;
      end
      pcl_pkg::S_FIND: begin
        if (stat.out_free) state_next = pcl_pkg::S_IDLE;
      end
      default: state_next = pcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd = '0;
    case (state)
      pcl_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load_op = s_tvalid;
      end
      pcl_pkg::S_EXEC: begin
        cmd.scan = stat.is_locate;
        cmd.commit = !stat.is_locate && stat.out_free;
      end
      pcl_pkg::S_FIND: begin
        cmd.find = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/pcl_dp.sv @@
// Datapath for the positional byte list: operation register, shifting cell
// row, count, match vector with priority search, and the output register.
// Depends on pcl_pkg.
module pcl_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pcl_pkg::IN_W-1:0]     s_tdata,
  input  pcl_pkg::cmd_t                cmd,
  output pcl_pkg::stat_t               stat,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pcl_pkg::OUT_W-1:0]    m_tdata
);

  logic [pcl_pkg::FUNC_W-1:0] func_q;
  logic [pcl_pkg::POS_W-1:0]  pos_q;
  logic [pcl_pkg::VAL_W-1:0]  val_q;
  logic [pcl_pkg::VAL_W-1:0]  cells [pcl_pkg::DEPTH];
  logic [pcl_pkg::CNT_W-1:0]  count;
  logic [pcl_pkg::DEPTH-1:0]  hit_vec;

  logic [pcl_pkg::STAT_W-1:0] out_st;
  logic [pcl_pkg::POS_W-1:0]  out_pos;
  logic [pcl_pkg::VAL_W-1:0]  out_el;
  logic [pcl_pkg::POS_W-1:0]  out_len;

  logic [pcl_pkg::POS_W-1:0]  pos_m1;
  logic [pcl_pkg::IDX_W-1:0]  idx;
  logic [pcl_pkg::VAL_W-1:0]  rd_el;
  pcl_pkg::pos_ext_t          pos_ext;
  pcl_pkg::pos_ext_t          cnt_ext;

  logic [pcl_pkg::STAT_W-1:0] r_st;
  logic [pcl_pkg::POS_W-1:0]  r_pos;
  logic [pcl_pkg::VAL_W-1:0]  r_el;
  logic [pcl_pkg::CNT_W-1:0]  count_next;
  logic                       do_ins;
  logic                       do_del;

  logic [pcl_pkg::POS_W-1:0]  hit_pos;
  logic                       hit_any;

  assign pos_m1  = pos_q - pcl_pkg::POS_W'(1);
  assign idx     = pos_m1[pcl_pkg::IDX_W-1:0];
  assign rd_el   = cells[idx];
  assign pos_ext = pcl_pkg::pos_ext_t'(pos_q);
  assign cnt_ext = pcl_pkg::pos_ext_t'(count);

  assign stat.is_locate = (func_q == pcl_pkg::FN_LOCATE);
  assign stat.out_free  = !m_tvalid || m_tready;

  assign m_tdata = {out_len, out_el, out_pos, out_st};

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      func_q <= s_tdata[pcl_pkg::FUNC_W-1:0];
      pos_q  <= s_tdata[pcl_pkg::FUNC_W +: pcl_pkg::POS_W];
      val_q  <= s_tdata[pcl_pkg::FUNC_W + pcl_pkg::POS_W +: pcl_pkg::VAL_W];
    end
  end

  // Result and count for every operation but locate.
  always_comb begin
    r_st = pcl_pkg::ST_RANGE;
    r_pos = '0;
    r_el = '0;
    count_next = count;
    do_ins = 1'b0;
    do_del = 1'b0;
    case (func_q)
      pcl_pkg::FN_CLEAR: begin
        r_st = pcl_pkg::ST_OK;
        count_next = '0;
      end
      pcl_pkg::FN_INSERT: begin
        r_pos = pos_q;
        if (cnt_ext >= pcl_pkg::pos_ext_t'(pcl_pkg::DEPTH)) begin
          r_st = pcl_pkg::ST_FULL;
        end else if (pos_q == '0 || pos_ext > cnt_ext + pcl_pkg::pos_ext_t'(1)) begin
          r_st = pcl_pkg::ST_RANGE;
        end else begin
          r_st = pcl_pkg::ST_OK;
          r_el = val_q;
          count_next = count + pcl_pkg::CNT_W'(1);
          do_ins = 1'b1;
        end
      end
      pcl_pkg::FN_DELETE, pcl_pkg::FN_READ: begin
        r_pos = pos_q;
        if (count == '0) begin
          r_st = pcl_pkg::ST_NONE;
        end else if (pos_q == '0 || pos_ext > cnt_ext) begin
          r_st = pcl_pkg::ST_RANGE;
        end else begin
          r_st = pcl_pkg::ST_OK;
          r_el = rd_el;
          if (func_q == pcl_pkg::FN_DELETE) begin
            count_next = count - pcl_pkg::CNT_W'(1);
            do_del = 1'b1;
          end
        end
      end
      default: begin
        r_st = pcl_pkg::ST_RANGE;
      end
    endcase
  end

  // First set bit of the registered match vector.
  always_comb begin
    hit_pos = '0;
    for (int i = pcl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_pos = pcl_pkg::POS_W'(i + 1);
    end
  end
  assign hit_any = |hit_vec;

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      for (int i = 0; i < pcl_pkg::DEPTH; i++) begin
        hit_vec[i] <= (cells[i] == val_q) && (pcl_pkg::CNT_W'(i) < count);
      end
    end
  end

  // Cell row: insert shifts cells from the position up; delete shifts down.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_ins) begin
      for (int i = 0; i < pcl_pkg::DEPTH; i++) begin
        if (pcl_pkg::IDX_W'(i) == idx) begin
          cells[i] <= val_q;
        end else if (i > 0 && pcl_pkg::IDX_W'(i) > idx) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end
    end else if (cmd.commit && do_del) begin
      for (int i = 0; i < pcl_pkg::DEPTH - 1; i++) begin
        if (pcl_pkg::IDX_W'(i) >= idx) cells[i] <= cells[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit || cmd.find) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_st  <= r_st;
      out_pos <= r_pos;
      out_el  <= r_el;
      out_len <= pcl_pkg::POS_W'(count_next);
    end else if (cmd.find) begin
      out_st  <= hit_any ? pcl_pkg::ST_OK : pcl_pkg::ST_NONE;
      out_pos <= hit_any ? hit_pos : '0;
      out_el  <= hit_any ? val_q : '0;
      out_len <= pcl_pkg::POS_W'(count);
    end
  end

endmodule

@@ sv/positional_char_list.sv @@
// Positional byte list, top level. Clear, insert, delete and read pass the
// operation register, then the output register; locate also registers the
// match vector over all cells before the priority search. A new transaction
// is accepted only after the last result is written to a free output
// register. Synchronous reset empties the list and clears the controller
// and output valid; cell contents are not reset.
module positional_char_list (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [2:0] func, [9:3] position, [17:10] value, [23:18] zero
  input  logic [pcl_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [1:0] status, [8:2] found_position, [16:9] element, [23:17] length
  output logic [pcl_pkg::OUT_W-1:0] m_tdata
);

  pcl_pkg::cmd_t  cmd;
  pcl_pkg::stat_t stat;

  pcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
